[rtl/cstt_pkg.sv]
// Shared types and codes for the client slot table.
// Used by cstt_cell and client_slot_table_stuck_timeout; no dependencies.
package cstt_pkg;

    localparam logic [3:0] CMD_CONNECT    = 4'd0;
    localparam logic [3:0] CMD_DISCONNECT = 4'd1;
    localparam logic [3:0] CMD_RX         = 4'd2;
    localparam logic [3:0] CMD_SEND_CHECK = 4'd3;
    localparam logic [3:0] CMD_SEND_FAIL  = 4'd4;
    localparam logic [3:0] CMD_SEND_OK    = 4'd5;
    localparam logic [3:0] CMD_SWEEP      = 4'd6;
    localparam logic [3:0] CMD_RESET      = 4'd7;
    localparam logic [3:0] CMD_LOOKUP     = 4'd8;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    localparam logic [31:0] TIMEOUT_RST = 32'd10000;
    localparam logic [4:0]  LIMIT_RST   = 5'd3;

    // command token handed from cell to cell
    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] id;
        logic [3:0]  sn;
        logic [31:0] now;
        logic        hit;
        logic [3:0]  slot;
        logic        acc;
        logic        drop;
    } t_tok;

    // close request from a cell during sweep
    typedef struct packed {
        logic        req;
        logic [31:0] id;
    } t_emit;

    typedef struct packed {
        logic        kind;
        logic        found;
        logic [3:0]  slot;
        logic [31:0] id;
        logic        acc;
        logic        drop;
        logic        last;
    } t_res;

endpackage

[rtl/cstt_cell.sv]
// One slot of the table: slot state plus the token register to the next cell.
// Depends on cstt_pkg.
module cstt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic [31:0]     i_timeout,
    input  logic [4:0]      i_limit,
    input  logic            i_tok_valid,
    input  cstt_pkg::t_tok  i_tok,
    output logic            o_tok_valid,
    output cstt_pkg::t_tok  o_tok,
    output cstt_pkg::t_emit o_emit
);
    import cstt_pkg::*;

    localparam logic [3:0] IDX = 4'(CELL_IDX);

    logic [31:0] r_id;
    logic        r_stuck;
    logic [31:0] r_st;
    logic [31:0] r_rx;
    logic [31:0] n_id;
    logic        n_stuck;
    logic [31:0] n_st;
    logic [31:0] n_rx;
    logic        r_tok_valid;
    t_tok        r_tok;
    t_tok        n_tok;

    logic        occupied;
    logic        is_find;
    logic        match;
    logic        claim;
    logic        in_lim;
    logic        expired;
    logic        rx_recent;
    logic        do_close;
    logic [31:0] st_age;
    logic [31:0] rx_age;

    assign occupied  = (r_id != 32'd0);
    assign is_find   = (i_tok.cmd == CMD_DISCONNECT) || (i_tok.cmd == CMD_RX) ||
                       (i_tok.cmd == CMD_SEND_CHECK) || (i_tok.cmd == CMD_SEND_FAIL) ||
                       (i_tok.cmd == CMD_SEND_OK);
    assign match     = is_find && !i_tok.hit && (i_tok.id != 32'd0) && (r_id == i_tok.id);
    assign claim     = (i_tok.cmd == CMD_CONNECT) && !i_tok.hit &&
                       (i_tok.id != 32'd0) && !occupied;
    assign in_lim    = ({1'b0, IDX} < i_limit);
    assign st_age    = i_tok.now - r_st;
    assign rx_age    = i_tok.now - r_rx;
    assign expired   = r_stuck && (st_age > i_timeout);
    assign rx_recent = (rx_age <= i_timeout);
    assign do_close  = (i_tok.cmd == CMD_SWEEP) && expired && occupied && !rx_recent;

    assign o_emit.req = i_tok_valid && do_close;
    assign o_emit.id  = r_id;

    always_comb begin
        n_id    = r_id;
        n_stuck = r_stuck;
        n_st    = r_st;
        n_rx    = r_rx;
        n_tok   = i_tok;
        case (i_tok.cmd)
            CMD_CONNECT: begin
                if (claim) begin
                    n_tok.hit  = 1'b1;
                    n_tok.slot = IDX;
                    n_tok.acc  = in_lim;
                    n_stuck    = 1'b0;
                    n_st       = 32'd0;
                    n_id       = in_lim ? i_tok.id : 32'd0;
                    n_rx       = in_lim ? i_tok.now : 32'd0;
                end
            end
            CMD_DISCONNECT, CMD_RX, CMD_SEND_CHECK, CMD_SEND_FAIL, CMD_SEND_OK: begin
                if (match) begin
                    n_tok.hit  = 1'b1;
                    n_tok.slot = IDX;
                    n_tok.drop = (i_tok.cmd == CMD_SEND_CHECK) && r_stuck;
                    if (i_tok.cmd == CMD_DISCONNECT) begin
                        n_id    = 32'd0;
                        n_stuck = 1'b0;
                        n_st    = 32'd0;
                        n_rx    = 32'd0;
                    end else if (i_tok.cmd == CMD_RX) begin
                        n_rx    = i_tok.now;
                        n_stuck = 1'b0;
                    end else if (i_tok.cmd == CMD_SEND_FAIL) begin
                        if (!r_stuck) begin
                            n_stuck = 1'b1;
                            n_st    = i_tok.now;
                        end
                    end else if (i_tok.cmd == CMD_SEND_OK) begin
                        n_stuck = 1'b0;
                    end
                end
            end
            CMD_SWEEP: begin
                if (do_close) begin
                    n_id    = 32'd0;
                    n_stuck = 1'b0;
                    n_st    = 32'd0;
                    n_rx    = 32'd0;
                end else if (expired) begin
                    n_stuck = 1'b0;
                end
            end
            CMD_RESET: begin
                n_id    = 32'd0;
                n_stuck = 1'b0;
                n_st    = 32'd0;
                n_rx    = 32'd0;
            end
            CMD_LOOKUP: begin
                if (i_tok.sn == IDX) begin
                    n_tok.hit = occupied;
                    n_tok.id  = r_id;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id        <= 32'd0;
            r_stuck     <= 1'b0;
            r_st        <= 32'd0;
            r_rx        <= 32'd0;
            r_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_tok_valid <= i_tok_valid;
            if (i_tok_valid) begin
                r_id    <= n_id;
                r_stuck <= n_stuck;
                r_st    <= n_st;
                r_rx    <= n_rx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

[rtl/client_slot_table_stuck_timeout.sv]
// Top level of the client slot table: input register, chain of slot cells,
// result register and configuration registers. Depends on cstt_pkg, cstt_cell.
//
// Each command beat enters an input register and then walks the row of SLOTS
// cells, one cell per cycle unless the chain halts; every cell applies the
// command to its own slot. The result register offers the acknowledge once the
// command has passed every cell, and the next command is taken at the end of the
// cycle in which it is first offered at the earliest. A sweep emits each close
// beat as the command passes the closing cell; the chain halts whenever a result
// cannot enter the output register. Configuration writes are taken only while
// no command is in the chain; nothing is taken during reset.
module client_slot_table_stuck_timeout #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_command,
    input  logic [31:0] i_client_id,
    input  logic [3:0]  i_slot_number,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic        o_found,
    output logic [3:0]  o_slot_out,
    output logic [31:0] o_id_out,
    output logic        o_accepted,
    output logic        o_drop_frame,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import cstt_pkg::*;

    logic [31:0] r_timeout;
    logic [4:0]  r_limit;

    logic        r_v0;
    t_tok        r_tok0;
    t_tok        n_tok0;

    logic        w_tv   [SLOTS];
    t_tok        w_tok  [SLOTS];
    t_emit       w_emit [SLOTS];
    logic        c_tv   [SLOTS];
    t_tok        c_tok  [SLOTS];

    logic        busy;
    logic        emit_any;
    logic [31:0] emit_id;
    logic [3:0]  emit_slot;
    logic        fin_valid;
    t_tok        fin;
    logic        out_free;
    logic        adv;
    logic        load;
    logic        in_acc;
    t_res        r_out;
    t_res        n_out;
    t_res        ack;

    assign o_cfg_ready = i_rst_n && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_LIMIT:   r_limit   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        busy      = r_v0;
        emit_any  = 1'b0;
        emit_id   = 32'd0;
        emit_slot = 4'd0;
        for (int k = 0; k < SLOTS; k++) begin
            busy     = busy | w_tv[k];
            emit_any = emit_any | w_emit[k].req;
            if (w_emit[k].req) begin
                emit_id   = emit_id | w_emit[k].id;
                emit_slot = emit_slot | 4'(k);
            end
        end
    end

    assign fin_valid  = w_tv[SLOTS-1];
    assign fin        = w_tok[SLOTS-1];
    assign out_free   = !o_out_valid || i_out_ready;
    assign adv        = out_free || !(emit_any || fin_valid);
    assign load       = adv && (emit_any || fin_valid);
    assign o_in_ready = i_rst_n && !busy;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_tok0      = '0;
        n_tok0.cmd  = i_command;
        n_tok0.id   = (i_command == CMD_LOOKUP) ? 32'd0 : i_client_id;
        n_tok0.sn   = i_slot_number;
        n_tok0.now  = i_now_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (in_acc) begin
            r_v0 <= 1'b1;
        end else if (adv) begin
            r_v0 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tok0 <= n_tok0;
        end
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign c_tv[k]  = r_v0;
            assign c_tok[k] = r_tok0;
        end else begin : g_link
            assign c_tv[k]  = w_tv[k-1];
            assign c_tok[k] = w_tok[k-1];
        end
        cstt_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (adv),
            .i_timeout   (r_timeout),
            .i_limit     (r_limit),
            .i_tok_valid (c_tv[k]),
            .i_tok       (c_tok[k]),
            .o_tok_valid (w_tv[k]),
            .o_tok       (w_tok[k]),
            .o_emit      (w_emit[k])
        );
    end

    always_comb begin
        ack      = '0;
        ack.last = 1'b1;
        case (fin.cmd)
            CMD_CONNECT: begin
                ack.found = fin.hit;
                ack.slot  = fin.slot;
                ack.id    = fin.id;
                ack.acc   = fin.acc;
            end
            CMD_DISCONNECT, CMD_RX, CMD_SEND_CHECK, CMD_SEND_FAIL, CMD_SEND_OK: begin
                ack.found = fin.hit;
                ack.slot  = fin.slot;
                ack.id    = fin.hit ? fin.id : 32'd0;
                ack.drop  = fin.drop;
            end
            CMD_LOOKUP: begin
                ack.found = fin.hit;
                ack.slot  = fin.sn;
                ack.id    = fin.id;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (emit_any) begin
            n_out       = '0;
            n_out.kind  = 1'b1;
            n_out.found = 1'b1;
            n_out.slot  = emit_slot;
            n_out.id    = emit_id;
        end else begin
            n_out = ack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_kind       = r_out.kind;
    assign o_found      = r_out.found;
    assign o_slot_out   = r_out.slot;
    assign o_id_out     = r_out.id;
    assign o_accepted   = r_out.acc;
    assign o_drop_frame = r_out.drop;
    assign o_last       = r_out.last;

endmodule
